/* hdl/tbp_pkg.sv */
`timescale 1ns / 1ps

package tbp_pkg;

    // Default sizes handed to the top level.
    localparam int DEF_NUM_FLOWS = 256;
    localparam int DEF_TIME_BITS = 32;

    // Fixed field widths.
    localparam int FLOW_ID_W   = 8;
    localparam int FLOW_ID_SPAN = 1 << FLOW_ID_W;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 1;

    // Token levels are 16.8 unsigned fixed point.
    localparam int FRAC_BITS = 8;
    localparam int LEVEL_W   = CFG_W + FRAC_BITS;
    localparam int PROD_W    = LEVEL_W + CFG_W;
    localparam logic [LEVEL_W-1:0] ONE_TOKEN = LEVEL_W'(1) << FRAC_BITS;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_REFILL_RATE = 1'b1;
    localparam logic [CFG_W-1:0] CAPACITY_RESET    = 16'd5;
    localparam logic [CFG_W-1:0] REFILL_RATE_RESET = 16'd256;

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_MUL  = 4'b0100,
        S_UPD  = 4'b1000
    } tbp_state_t;

    // Stage enables from the sequencer to the refill datapath.
    typedef struct packed {
        logic load;
        logic mul;
        logic upd;
    } tbp_ctrl_t;

endpackage

/* hdl/tbp_ram.sv */
`timescale 1ns / 1ps

// Simple dual-port RAM with a registered read.
module tbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/tbp_refill.sv */
`timescale 1ns / 1ps

// Bucket arithmetic: elapsed time, refill product, saturation and take.
module tbp_refill
    import tbp_pkg::*;
#(
    parameter int TIME_BITS = DEF_TIME_BITS
) (
    input  logic                 clk,
    input  tbp_ctrl_t            ctrl,
    input  logic                 seen,
    input  logic [LEVEL_W-1:0]   level_rd,
    input  logic [TIME_BITS-1:0] last_rd,
    input  logic [TIME_BITS-1:0] now,
    input  logic [CFG_W-1:0]     capacity,
    input  logic [CFG_W-1:0]     refill_rate,
    output logic [LEVEL_W-1:0]   level_new,
    output logic                 allowed_new
);

    localparam int EXT_W = (TIME_BITS > LEVEL_W) ? TIME_BITS : LEVEL_W + 1;

    logic [LEVEL_W-1:0]   limit;
    logic [TIME_BITS-1:0] elapsed;
    logic [EXT_W-1:0]     elapsed_ext;
    logic                 elapsed_sat;
    logic [LEVEL_W-1:0]   level_reg;
    logic [LEVEL_W-1:0]   elap_reg;
    logic                 sat_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [PROD_W:0]      sum;
    logic [LEVEL_W-1:0]   refilled;

    assign limit       = {capacity, {FRAC_BITS{1'b0}}};
    assign elapsed     = now - last_rd;
    assign elapsed_ext = EXT_W'(elapsed);
    assign elapsed_sat = |elapsed_ext[EXT_W-1:LEVEL_W];

    // A flow seen for the first time starts full with no elapsed time.
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            level_reg <= seen ? level_rd : limit;
            elap_reg  <= seen ? elapsed_ext[LEVEL_W-1:0] : '0;
            sat_reg   <= seen & elapsed_sat;
        end
        if (ctrl.mul)
        begin
            prod_reg <= elap_reg * refill_rate;
        end
    end

    always_comb
    begin
        sum = {{(PROD_W + 1 - LEVEL_W){1'b0}}, level_reg} + {1'b0, prod_reg};
        if (sat_reg && (refill_rate != '0))
        begin
            refilled = limit;
        end
        else if (sum > {{(PROD_W + 1 - LEVEL_W){1'b0}}, limit})
        begin
            refilled = limit;
        end
        else
        begin
            refilled = sum[LEVEL_W-1:0];
        end
        allowed_new = (refilled >= ONE_TOKEN);
        level_new   = allowed_new ? (refilled - ONE_TOKEN) : refilled;
    end

endmodule

/* hdl/token_bucket_policer.sv */
`timescale 1ns / 1ps

// Channel      Direction  Signals                         Handshake
// request      in         flow_id, timestamp              start while busy is low
// result       out        allowed                         done, one cycle, no stall
// config       in         cfg_index, cfg_wdata            cfg_we, written at once
//
// Each item passes, from acceptance to the next acceptance, through the
// bucket memory read, the refill multiply, the update and write-back,
// and the idle state in which done is shown. The read-modify-write of
// the bucket memory sets this sequence; busy holds the next item off
// until the write-back is done, so accesses never overlap.
// Reset clears the seen marks and the sequencer at once; no clearing pass.
// The receiver cannot stall: done and allowed are valid for one cycle.
module token_bucket_policer
    import tbp_pkg::*;
#(
    parameter int NUM_FLOWS = DEF_NUM_FLOWS,
    parameter int TIME_BITS = DEF_TIME_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [FLOW_ID_W-1:0] flow_id,
    input  logic [31:0]          timestamp,
    output logic                 done,
    output logic                 allowed,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    // Only flow_id values can reach the table, so at most FLOW_ID_SPAN
    // buckets are ever touched, whatever NUM_FLOWS is.
    localparam int FLOWS_USED = (NUM_FLOWS < FLOW_ID_SPAN) ? NUM_FLOWS : FLOW_ID_SPAN;
    localparam int IDX_W      = $clog2(FLOWS_USED);
    localparam int ENTRY_W    = TIME_BITS + LEVEL_W;

    tbp_state_t             state_reg, state_next;
    tbp_ctrl_t              ctrl;
    logic [CFG_W-1:0]       capacity_reg;
    logic [CFG_W-1:0]       refill_rate_reg;
    logic [IDX_W-1:0]       flow_map [FLOW_ID_SPAN];
    logic [IDX_W-1:0]       idx_in;
    logic [IDX_W-1:0]       idx_reg;
    logic [TIME_BITS-1:0]   now_reg;
    logic [FLOWS_USED-1:0]  seen_reg;
    logic                   accept;
    logic [ENTRY_W-1:0]     rd_entry;
    logic [ENTRY_W-1:0]     wr_entry;
    logic [LEVEL_W-1:0]     level_new;
    logic                   allowed_new;
    logic                   done_reg;
    logic                   allowed_reg;

    // Flow index modulo NUM_FLOWS as a constant lookup table.
    for (genvar g = 0; g < FLOW_ID_SPAN; g++)
    begin : g_flow_map
        assign flow_map[g] = IDX_W'(g % NUM_FLOWS);
    end

    assign idx_in = flow_map[flow_id];
    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        ctrl.load = (state_reg == S_READ);
        ctrl.mul  = (state_reg == S_MUL);
        ctrl.upd  = (state_reg == S_UPD);
    end

    always_comb
    begin
        case (state_reg)
            S_IDLE:  state_next = accept ? S_READ : S_IDLE;
            S_READ:  state_next = S_MUL;
            S_MUL:   state_next = S_UPD;
            S_UPD:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            capacity_reg    <= CAPACITY_RESET;
            refill_rate_reg <= REFILL_RATE_RESET;
            seen_reg        <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= ctrl.upd;
            if (ctrl.upd)
            begin
                seen_reg[idx_reg] <= 1'b1;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CAPACITY:    capacity_reg    <= cfg_wdata;
                    REG_REFILL_RATE: refill_rate_reg <= cfg_wdata;
                    default:         ;
                endcase
            end
        end
    end

    // Item payload, captured at acceptance and held through the update.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg <= idx_in;
            now_reg <= TIME_BITS'(timestamp);
        end
        if (ctrl.upd)
        begin
            allowed_reg <= allowed_new;
        end
    end

    // Each entry holds the last update time above the token level.
    assign wr_entry = {now_reg, level_new};

    tbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (FLOWS_USED)
    ) u_bucket_ram (
        .clk   (clk),
        .we    (ctrl.upd),
        .waddr (idx_reg),
        .wdata (wr_entry),
        .re    (accept),
        .raddr (idx_in),
        .rdata (rd_entry)
    );

    // The stored fields are only used when the seen mark is set, so an
    // entry that was never written does not affect the result.
    tbp_refill #(
        .TIME_BITS (TIME_BITS)
    ) u_refill (
        .clk         (clk),
        .ctrl        (ctrl),
        .seen        (seen_reg[idx_reg]),
        .level_rd    (rd_entry[LEVEL_W-1:0]),
        .last_rd     (rd_entry[ENTRY_W-1:LEVEL_W]),
        .now         (now_reg),
        .capacity    (capacity_reg),
        .refill_rate (refill_rate_reg),
        .level_new   (level_new),
        .allowed_new (allowed_new)
    );

    assign done    = done_reg;
    assign allowed = allowed_reg;

    // A result appears only in the cycle after a write-back.
    a_done_after_upd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_UPD))
        else $error("done without a preceding update");

    // An accepted item always starts with the memory read.
    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_READ))
        else $error("accepted item did not enter the read state");

    // After a write-back the flow is marked as seen.
    a_seen_after_upd: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.upd |=> seen_reg[$past(idx_reg)])
        else $error("flow not marked seen after update");

    // A bucket with zero capacity never admits a request.
    a_zero_cap_denies: assert property (@(posedge clk) disable iff (!rst_n)
        (done && allowed) |-> (capacity_reg != '0))
        else $error("request admitted with zero capacity");

endmodule

/* tb/token_bucket_policer_tb.sv */
`timescale 1ns / 1ps

module token_bucket_policer_tb;
    import tbp_pkg::*;

    // One request as the driver holds it until the block takes it.
    typedef struct packed {
        logic [FLOW_ID_W-1:0] flow;
        logic [31:0]          ts;
    } request_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [FLOW_ID_W-1:0] flow_id = '0;
    logic [31:0]          timestamp = '0;
    logic                 done;
    logic                 allowed;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_CAPACITY;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    token_bucket_policer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .flow_id   (flow_id),
        .timestamp (timestamp),
        .done      (done),
        .allowed   (allowed),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Requests waiting to be presented, and the admit decisions that the
    // block still owes us, oldest first.
    request_t req_q[$];
    logic     admit_q[$];

    // Shadow copy of the policer: configuration and the per-flow buckets.
    logic [CFG_W-1:0]   cap_cfg  = CAPACITY_RESET;
    logic [CFG_W-1:0]   rate_cfg = REFILL_RATE_RESET;
    logic [LEVEL_W-1:0] level_mem [FLOW_ID_SPAN];
    logic [31:0]        stamp_mem [FLOW_ID_SPAN];
    logic               seen_mem  [FLOW_ID_SPAN];

    int   errors = 0;
    int   gap_left = 0;
    logic idle_on = 1'b0;

    // The hot flows get most of the traffic so that buckets actually drain;
    // they stay the same for the whole run so that their levels carry over
    // from one configuration to the next.
    logic [FLOW_ID_W-1:0] hot_flows [4];
    logic [31:0]          tick;

    initial
    begin
        for (int i = 0; i < FLOW_ID_SPAN; i++)
        begin
            seen_mem[i] = 1'b0;
        end
    end

    // Works out whether one request is admitted and updates the shadow bucket.
    // A flow seen for the first time starts full. Otherwise the bucket gains
    // elapsed ticks times the rate, where elapsed wraps modulo 2^32, and with a
    // nonzero rate an elapsed count of 2^24 or more fills it outright. The
    // level is always clamped to the current capacity, which also pulls down a
    // bucket that was filled under a higher capacity.
    function automatic logic police_request(input logic [FLOW_ID_W-1:0] flow,
                                            input logic [31:0] ts);
        logic [63:0] limit;
        logic [63:0] sum;
        logic [63:0] elapsed;
        logic [31:0] delta;
        limit = 64'(cap_cfg) << FRAC_BITS;
        if (!seen_mem[flow])
        begin
            seen_mem[flow] = 1'b1;
            sum = limit;
        end
        else
        begin
            delta = ts - stamp_mem[flow];
            elapsed = 64'(delta);
            if (rate_cfg == '0)
                sum = 64'(level_mem[flow]);
            else if (elapsed >= (64'd1 << 24))
                sum = limit;
            else
                sum = 64'(level_mem[flow]) + elapsed * 64'(rate_cfg);
        end
        if (sum > limit)
            sum = limit;
        stamp_mem[flow] = ts;
        if (sum >= 64'(ONE_TOKEN))
        begin
            level_mem[flow] = LEVEL_W'(sum - 64'(ONE_TOKEN));
            return 1'b1;
        end
        level_mem[flow] = LEVEL_W'(sum);
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        errors++;
    endtask

    // Driver. An item is taken at an edge where start is high and busy is
    // low; the decision is predicted right there, since the configuration
    // cannot change while items are in flight. After each item it idles for
    // a drawn number of cycles, or not at all when idling is switched off.
    // When the next item follows at once, start simply stays high.
    always @(posedge clk)
    begin
        request_t req;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                admit_q.insert(admit_q.size(), police_request(flow_id, timestamp));
                gap_left = idle_on ? $urandom_range(0, 10) : 0;
            end
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (req_q.size() > 0)
                begin
                    req = req_q[0];
                    req_q.delete(0);
                    flow_id   <= req.flow;
                    timestamp <= req.ts;
                    start     <= 1'b1;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor. done is high for exactly one cycle per result and cannot be
    // held off, so every edge with done high carries a decision to check.
    always @(posedge clk)
    begin
        logic want;
        if (rst_n && done)
        begin
            if (admit_q.size() == 0)
            begin
                report_mismatch("result with no request outstanding");
            end
            else
            begin
                want = admit_q[0];
                admit_q.delete(0);
                if (allowed !== want)
                    report_mismatch($sformatf("allowed=%b, expected %b", allowed, want));
            end
        end
    end

    task automatic add_request(input logic [FLOW_ID_W-1:0] flow, input logic [31:0] ts);
        request_t req;
        req.flow = flow;
        req.ts   = ts;
        req_q.insert(req_q.size(), req);
    endtask

    // Waits until every queued item has been taken and answered. Checked on
    // the falling edge, where all updates of the rising edge have settled.
    // The block shows done in its idle cycle, so the extra wait after that is
    // only a margin before the configuration is touched.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (req_q.size() != 0 || start || admit_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_CAPACITY)
            cap_cfg = val;
        else
            rate_cfg = val;
    endtask

    // Drains the block, sets both registers and picks whether the driver
    // idles between items during the coming phase.
    task automatic new_setting(input logic [CFG_W-1:0] cap, input logic [CFG_W-1:0] rate);
        wait_drained();
        write_reg(REG_CAPACITY, cap);
        write_reg(REG_REFILL_RATE, rate);
        idle_on = ($urandom_range(0, 3) != 0);
    endtask

    // Random traffic. Most requests go to the hot flows with small or zero
    // time steps, so buckets empty and refill and both outcomes show up.
    // The rest hit any flow, jump far ahead, jump to a fully random time
    // (often backward, which reads as a long wrapped interval) or step
    // to or just past the point where the bucket fills outright.
    task automatic random_requests(input int n);
        int                   kind;
        logic [FLOW_ID_W-1:0] flow;
        for (int i = 0; i < n; i++)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 7)
                flow = hot_flows[$urandom_range(0, 3)];
            else
                flow = FLOW_ID_W'($urandom_range(0, FLOW_ID_SPAN - 1));
            case (kind)
                7:       tick += $urandom_range(0, 1 << 20);
                8:       tick = $urandom();
                9:       tick += 32'h0100_0000 + $urandom_range(0, 3);
                6:       ;
                default:
                begin
                    if ($urandom_range(0, 2) == 0)
                        tick += $urandom_range(1, 4);
                end
            endcase
            add_request(flow, tick);
        end
    endtask

    initial
    begin
        for (int i = 0; i < 4; i++)
        begin
            hot_flows[i] = FLOW_ID_W'($urandom_range(0, FLOW_ID_SPAN - 1));
        end
        tick = $urandom();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset configuration: five tokens, one token
        // per tick. The first request fills flow 0, four more drain it at
        // the same time, and the sixth is denied.
        idle_on = 1'b1;
        repeat (6) add_request(8'd0, 32'd0);
        // One tick later exactly one token has come back.
        add_request(8'd0, 32'd1);
        // Going back to time 0 wraps to a huge interval and refills fully.
        add_request(8'd0, 32'd0);
        // The top flow index and the top timestamp, then a wrap by one tick.
        add_request(8'd255, 32'hFFFF_FFFF);
        add_request(8'd255, 32'h0000_0000);
        add_request(8'd255, 32'h0000_0000);
        // Intervals just below and exactly at 2^24: the first saturates
        // through the clamp, the second fills the bucket outright.
        add_request(8'd128, 32'h0000_0000);
        add_request(8'd128, 32'h00FF_FFFF);
        add_request(8'd128, 32'h0100_0000);
        add_request(8'd128, 32'h0200_0000);
        add_request(8'd128, 32'h0300_0000);
        add_request(8'd85, 32'hAAAA_AAAA);
        add_request(8'd170, 32'h5555_5555);
        add_request(8'd170, 32'h5555_5555);
        for (int i = 0; i < 4; i++)
        begin
            add_request(hot_flows[i], tick);
        end

        // Smallest nonzero capacity with no refill: buckets never come back.
        new_setting(16'd1, 16'd0);
        random_requests(90);
        // Largest capacity and rate: gains overflow the 24-bit level.
        new_setting(16'd65535, 16'd65535);
        random_requests(90);
        // Zero capacity: buckets filled above are clamped to nothing and
        // every request is denied.
        new_setting(16'd0, 16'd300);
        random_requests(70);
        new_setting(16'd8, 16'd64);
        random_requests(100);
        // Capacity lowered under buckets that may hold up to eight tokens.
        new_setting(16'd2, 16'd64);
        random_requests(90);
        // Large capacity with no refill: new flows start very full.
        new_setting(16'd65535, 16'd0);
        random_requests(70);
        new_setting(16'd3, 16'd1);
        random_requests(90);
        for (int p = 0; p < 4; p++)
        begin
            new_setting(CFG_W'($urandom_range(1, 16)), CFG_W'($urandom_range(0, 1024)));
            random_requests(80);
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog. A correct run ends well before it fires, even with the
    // longest gaps on every item.
    initial
    begin
        #3_000_000;
        $display("timeout at %0t ns", $time);
        $display("status: fail");
        $finish;
    end

endmodule
